### rtl/gn3_pkg.sv
`default_nettype none
package gn3_pkg;
  typedef enum logic {ACT_LOAD = 1'b0, ACT_EVAL = 1'b1} action_e;
endpackage
`default_nettype wire

### rtl/gn3_if.sv
`default_nettype none
interface gn3_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  entry_index;
  logic [7:0]  entry_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;
  modport source (output valid, action, entry_index, entry_value, x_coord, y_coord, z_coord,
                  input ready);
  modport sink (input valid, action, entry_index, entry_value, x_coord, y_coord, z_coord,
                output ready);
endinterface

interface gn3_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface
`default_nettype wire

### rtl/gn3_core.sv
`default_nettype none
// Permutation table replicated into one memory per lookup port. A load reaches
// each copy in step with the pipeline stage that reads it.
// Pipeline: three hash levels, then fade and blend math.
module gn3_core #(
  parameter int HASH_BITS = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic in_vld_i,
  input  wire logic in_act_i,
  input  wire logic [7:0] in_idx_i,
  input  wire logic [7:0] in_val_i,
  input  wire logic signed [31:0] in_x_i,
  input  wire logic signed [31:0] in_y_i,
  input  wire logic signed [31:0] in_z_i,
  output logic      out_vld_o,
  output logic signed [15:0] out_noise_o
);
  import gn3_pkg::*;
  localparam int HB = HASH_BITS;
  localparam int F = FRAC_BITS;
  localparam int N = 1 << HB;
  localparam int W = F + 6;
  localparam int NS = 14;
  localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< F);

  // per-stage registers
  logic [NS-1:0] v_q;
  logic [HB-1:0] x_q [NS], y_q [NS], z_q [NS];
  logic signed [W-1:0] fx_q [NS], fy_q [NS], fz_q [NS];

  logic wr;
  logic [HB-1:0] widx;
  assign wr = en_i && in_vld_i && (in_act_i == ACT_LOAD);
  assign widx = HB'(in_idx_i);
  logic [7:0] mem0 [N], mem1 [N], mem2 [N], mem3 [N], mem4 [N], mem5 [N], mem6 [N];
  logic [7:0] mem7 [N], mem8 [N], mem9 [N], mem10 [N], mem11 [N], mem12 [N], mem13 [N];

  // delay the load to the later copies so it lands between the requests
  // before and after it
  logic [1:0] wr_q;
  logic [HB-1:0] widx_q [2];
  logic [7:0] wval_q [2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
    end else if (en_i) begin
      wr_q <= {wr_q[0], wr};
    end
  end

  // stage 0: split coordinates, look up X and X+1
  logic [7:0] ta_q, tb_q;
  logic [31:0] gx, gy, gz;
  assign gx = 32'(in_x_i >>> F);
  assign gy = 32'(in_y_i >>> F);
  assign gz = 32'(in_z_i >>> F);
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem0[widx] <= in_val_i; mem1[widx] <= in_val_i;
    end
    if (en_i) begin
      ta_q <= mem0[gx[HB-1:0]];
      tb_q <= mem1[HB'(gx[HB-1:0] + 1'b1)];
      x_q[0] <= gx[HB-1:0]; y_q[0] <= gy[HB-1:0]; z_q[0] <= gz[HB-1:0];
      fx_q[0] <= W'({1'b0, in_x_i[F-1:0]});
      fy_q[0] <= W'({1'b0, in_y_i[F-1:0]});
      fz_q[0] <= W'({1'b0, in_z_i[F-1:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], in_vld_i && (in_act_i == ACT_EVAL)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      widx_q[0] <= widx; wval_q[0] <= in_val_i;
      widx_q[1] <= widx_q[0]; wval_q[1] <= wval_q[0];
      for (int i = 1; i < NS; i++) begin
        x_q[i] <= x_q[i-1]; y_q[i] <= y_q[i-1]; z_q[i] <= z_q[i-1];
        fx_q[i] <= fx_q[i-1]; fy_q[i] <= fy_q[i-1]; fz_q[i] <= fz_q[i-1];
      end
    end
  end

  // stage 1: pa, pb -> four lookups
  logic [HB-1:0] pa, pb;
  assign pa = HB'(ta_q) + y_q[0];
  assign pb = HB'(tb_q) + y_q[0];
  logic [7:0] tpa_q, tpa1_q, tpb_q, tpb1_q;
  always_ff @(posedge clk_i) begin
    if (en_i && wr_q[0]) begin
      mem2[widx_q[0]] <= wval_q[0]; mem3[widx_q[0]] <= wval_q[0];
      mem4[widx_q[0]] <= wval_q[0]; mem5[widx_q[0]] <= wval_q[0];
    end
    if (en_i) begin
      tpa_q <= mem2[pa]; tpa1_q <= mem3[HB'(pa + 1'b1)];
      tpb_q <= mem4[pb]; tpb1_q <= mem5[HB'(pb + 1'b1)];
    end
  end

  // stage 2: aa ab ba bb -> eight corner hashes
  logic [HB-1:0] aa, ab, ba, bb;
  assign aa = HB'(tpa_q) + z_q[1];
  assign ab = HB'(tpa1_q) + z_q[1];
  assign ba = HB'(tpb_q) + z_q[1];
  assign bb = HB'(tpb1_q) + z_q[1];
  logic [3:0] h_q [8];
  logic [7:0] r0, r1, r2, r3, r4, r5, r6, r7;
  always_ff @(posedge clk_i) begin
    if (en_i && wr_q[1]) begin
      mem6[widx_q[1]] <= wval_q[1]; mem7[widx_q[1]] <= wval_q[1];
      mem8[widx_q[1]] <= wval_q[1]; mem9[widx_q[1]] <= wval_q[1];
      mem10[widx_q[1]] <= wval_q[1]; mem11[widx_q[1]] <= wval_q[1];
      mem12[widx_q[1]] <= wval_q[1]; mem13[widx_q[1]] <= wval_q[1];
    end
    if (en_i) begin
      r0 <= mem6[aa]; r1 <= mem7[ba]; r2 <= mem8[ab]; r3 <= mem9[bb];
      r4 <= mem10[HB'(aa + 1'b1)]; r5 <= mem11[HB'(ba + 1'b1)];
      r6 <= mem12[HB'(ab + 1'b1)]; r7 <= mem13[HB'(bb + 1'b1)];
    end
  end
  always_comb begin
    h_q[0] = r0[3:0]; h_q[1] = r1[3:0]; h_q[2] = r2[3:0]; h_q[3] = r3[3:0];
    h_q[4] = r4[3:0]; h_q[5] = r5[3:0]; h_q[6] = r6[3:0]; h_q[7] = r7[3:0];
  end

  function automatic logic signed [W-1:0] grad(input logic [3:0] h,
      input logic signed [W-1:0] dx, input logic signed [W-1:0] dy,
      input logic signed [W-1:0] dz);
    logic signed [W-1:0] u, v;
    u = (h < 4'd8) ? dx : dy;
    v = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : dz);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  // stage 3: gradients (and fade step one) registered
  logic signed [W-1:0] g_q [8];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 8; c++) begin
        g_q[c] <= grad(h_q[c],
          c[0] ? fx_q[2] - ONE : fx_q[2],
          c[1] ? fy_q[2] - ONE : fy_q[2],
          c[2] ? fz_q[2] - ONE : fz_q[2]);
      end
    end
  end

  // fade over stages 3..6; the multiplies sit in stages 3, 5 and 6
  localparam int PW = 2 * W;
  logic signed [W-1:0] qa_q [3], t2_q [3], q_q [3], t3_q [3], fd_q [3];
  logic signed [W-1:0] tt [3];
  logic signed [PW-1:0] mq_q [3], mt_q [3];
  always_comb begin
    tt[0] = fx_q[2]; tt[1] = fy_q[2]; tt[2] = fz_q[2];
  end
  logic signed [W-1:0] tin_q [3], tin2_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        tin_q[k] <= tt[k];
        mq_q[k] <= PW'(tt[k]) * PW'(W'(15) * ONE - W'(6) * tt[k]);
        mt_q[k] <= PW'(tt[k]) * PW'(tt[k]);
        qa_q[k] <= W'(mq_q[k] >>> F);
        t2_q[k] <= W'(mt_q[k] >>> F);
        tin2_q[k] <= tin_q[k];
        q_q[k] <= W'(10) * ONE - qa_q[k];
        t3_q[k] <= W'((PW'(t2_q[k]) * PW'(tin2_q[k])) >>> F);
        fd_q[k] <= W'((PW'(t3_q[k]) * PW'(q_q[k])) >>> F);
      end
    end
  end
  // fd valid at stage 6 (from tt at stage 2: +4 registers); delay gradients to match
  logic signed [W-1:0] gd_q [3][8];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gd_q[0] <= g_q; gd_q[1] <= gd_q[0]; gd_q[2] <= gd_q[1];
    end
  end

  function automatic logic signed [W-1:0] lerp(input logic signed [W-1:0] w,
      input logic signed [W-1:0] a, input logic signed [W-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(w) * PW'(b - a);
    return a + W'(p >>> F);
  endfunction

  // blend: x stage, y stage, z stage with fades held in line
  logic signed [W-1:0] xl_q [4], yl_q [2], rl_q;
  logic signed [W-1:0] fv_q, fw_q, fw2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xl_q[0] <= lerp(fd_q[0], gd_q[2][0], gd_q[2][1]);
      xl_q[1] <= lerp(fd_q[0], gd_q[2][2], gd_q[2][3]);
      xl_q[2] <= lerp(fd_q[0], gd_q[2][4], gd_q[2][5]);
      xl_q[3] <= lerp(fd_q[0], gd_q[2][6], gd_q[2][7]);
      fv_q <= fd_q[1]; fw_q <= fd_q[2];
      yl_q[0] <= lerp(fv_q, xl_q[0], xl_q[1]);
      yl_q[1] <= lerp(fv_q, xl_q[2], xl_q[3]);
      fw2_q <= fw_q;
      rl_q <= lerp(fw2_q, yl_q[0], yl_q[1]);
    end
  end

  logic signed [W+14:0] sc;
  always_comb begin
    if (F >= 14) sc = (W+15)'(rl_q >>> (F >= 14 ? F - 14 : 0));
    else sc = (W+15)'(rl_q) <<< (F < 14 ? 14 - F : 0);
    if (sc > 32767) out_noise_o = 16'sh7fff;
    else if (sc < -32768) out_noise_o = 16'sh8000;
    else out_noise_o = 16'(sc);
  end
  // eval flag: stages 0..2 hash, 3 grad, 4..6 delay, 7 x, 8 y, 9 z
  assign out_vld_o = v_q[9];

  logic unused;
  assign unused = ^{v_q[NS-1:10], x_q[NS-1], y_q[NS-1], z_q[NS-1],
                   fx_q[NS-1], fy_q[NS-1], fz_q[NS-1]};

  ap_load_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && in_vld_i && in_act_i == ACT_LOAD) |=> !v_q[0]) else $error("load entered pipe");
  ap_eval_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && in_vld_i && in_act_i == ACT_EVAL) |=> v_q[0]) else $error("eval not tracked");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(v_q)) else $error("pipe moved while stalled");
endmodule
`default_nettype wire

### rtl/gradient_noise_3d.sv
`default_nettype none
// An accepted evaluate request passes the core pipeline and then the output register before
// its result is valid. One request per cycle while not stalled; loads give no result.
// The whole pipeline advances only when the output register can take data.
// Reset clears valid flags only; the permutation memories hold garbage
// until loaded.
module gradient_noise_3d #(
  parameter int HASH_BITS = 8,
  parameter int FRAC_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  gn3_in_if.sink   in_i,
  gn3_out_if.source out_o
);
  import gn3_pkg::*;
  logic en, cv;
  logic signed [15:0] cn;
  logic vq;
  logic signed [15:0] nq;
  assign en = !vq || out_o.ready;
  assign in_i.ready = en;
  gn3_core #(.HASH_BITS(HASH_BITS), .FRAC_BITS(FRAC_BITS)) u_core (
    .clk_i, .rst_ni, .en_i(en), .in_vld_i(in_i.valid), .in_act_i(in_i.action),
    .in_idx_i(in_i.entry_index), .in_val_i(in_i.entry_value),
    .in_x_i(in_i.x_coord), .in_y_i(in_i.y_coord), .in_z_i(in_i.z_coord),
    .out_vld_o(cv), .out_noise_o(cn));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vq <= 1'b0;
    else if (en) vq <= cv;
  end
  always_ff @(posedge clk_i) begin
    if (en) nq <= cn;
  end
  assign out_o.valid = vq;
  assign out_o.noise_value = nq;
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vq && !out_o.ready) |=> (vq && $stable(nq))) else $error("result dropped");
  ap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vq |-> in_i.ready) else $error("stalled while empty");
  ap_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vq && !out_o.ready) |-> !in_i.ready) else $error("accepted into full pipe");
endmodule
`default_nettype wire

### tb/gradient_noise_3d_tb.sv
`default_nettype none
module gradient_noise_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gn3_pkg::*;

  localparam longint ONE = 64'sd65536;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_ITEMS = 200;

  typedef struct {
    action_e act;
    bit [7:0] idx;
    bit [7:0] val;
    bit signed [31:0] x;
    bit signed [31:0] y;
    bit signed [31:0] z;
    bit hold;  // wait for the pipeline to empty before this request
  } point_req_t;

  logic clk_i;
  logic rst_ni;

  gn3_in_if in_if ();
  gn3_out_if out_if ();

  gradient_noise_3d dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  point_req_t pending_reqs[$];
  logic signed [15:0] noise_expected[$];
  bit [7:0] perm_shadow[256];
  int mismatches = 0;
  int accepted_reqs = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  bit tail_phase = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint fade5(longint t);
    longint q, t3;
    q = 10 * ONE - ((t * (15 * ONE - 6 * t)) >>> 16);
    t3 = (((t * t) >>> 16) * t) >>> 16;
    return (t3 * q) >>> 16;
  endfunction

  function automatic longint lerp_fx(longint w, longint a, longint b);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic longint grad_dot(bit [7:0] hv, longint dx, longint dy, longint dz);
    bit [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? dx : dy;
    v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : dz);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [15:0] noise_at(bit signed [31:0] px, bit signed [31:0] py,
                                                  bit signed [31:0] pz);
    longint cx, cy, cz, fx, fy, fz, u, v, w, r;
    longint x00, x10, x01, x11, y0, y1;
    bit [7:0] cxi, cyi, czi, pa, pb, aa, ab, ba, bb;
    cx = px; cy = py; cz = pz;
    cxi = 8'(cx >>> 16); cyi = 8'(cy >>> 16); czi = 8'(cz >>> 16);
    fx = cx & 64'hFFFF; fy = cy & 64'hFFFF; fz = cz & 64'hFFFF;
    u = fade5(fx); v = fade5(fy); w = fade5(fz);
    pa = perm_shadow[cxi] + cyi;
    pb = perm_shadow[8'(cxi + 8'd1)] + cyi;
    aa = perm_shadow[pa] + czi;
    ab = perm_shadow[8'(pa + 8'd1)] + czi;
    ba = perm_shadow[pb] + czi;
    bb = perm_shadow[8'(pb + 8'd1)] + czi;
    x00 = lerp_fx(u, grad_dot(perm_shadow[aa], fx, fy, fz),
                  grad_dot(perm_shadow[ba], fx - ONE, fy, fz));
    x10 = lerp_fx(u, grad_dot(perm_shadow[ab], fx, fy - ONE, fz),
                  grad_dot(perm_shadow[bb], fx - ONE, fy - ONE, fz));
    x01 = lerp_fx(u, grad_dot(perm_shadow[8'(aa + 8'd1)], fx, fy, fz - ONE),
                  grad_dot(perm_shadow[8'(ba + 8'd1)], fx - ONE, fy, fz - ONE));
    x11 = lerp_fx(u, grad_dot(perm_shadow[8'(ab + 8'd1)], fx, fy - ONE, fz - ONE),
                  grad_dot(perm_shadow[8'(bb + 8'd1)], fx - ONE, fy - ONE, fz - ONE));
    y0 = lerp_fx(v, x00, x10);
    y1 = lerp_fx(v, x01, x11);
    r = lerp_fx(w, y0, y1) >>> 2;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic bit signed [31:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 32'h1FFFFF) - 32'sh100000;
  endfunction

  task automatic push_load(bit [7:0] i, bit [7:0] v, bit hold);
    point_req_t r;
    r.act = ACT_LOAD; r.idx = i; r.val = v; r.hold = hold;
    r.x = $urandom; r.y = $urandom; r.z = $urandom;
    pending_reqs.push_back(r);
  endtask

  task automatic push_eval(bit signed [31:0] x, bit signed [31:0] y, bit signed [31:0] z,
                           bit hold);
    point_req_t r;
    r.act = ACT_EVAL; r.idx = $urandom; r.val = $urandom; r.hold = hold;
    r.x = x; r.y = y; r.z = z;
    pending_reqs.push_back(r);
  endtask

  // Stimulus: full table load, directed points, then random traffic.
  initial begin
    int order[256];
    int j, tmp;
    for (int i = 0; i < 256; i++) order[i] = i;
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < 256; i++) push_load(8'(order[i]), 8'(order[(i + 37) % 256]), 0);
    push_load(8'd0, 8'd255, 0);
    push_load(8'd255, 8'd0, 0);
    push_eval(32'sh0, 32'sh0, 32'sh0, 0);
    push_eval(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    push_eval(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    push_eval(32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 0);
    push_eval(32'sh00008000, 32'sh00008000, 32'sh0, 0);
    push_eval(32'sh0000FFFF, 32'sh0000FFFF, 32'sh0000FFFF, 0);
    push_eval(32'shFFFFFFFF, 32'shFFFF0001, 32'shFFFF8000, 0);
    push_eval(32'sh00030000, 32'shFFFD0000, 32'sh00010000, 0);
    push_eval(32'sh00FF4000, 32'sh01004000, 32'shFF00C000, 0);
    push_eval(32'sh12345678, 32'shEDCBA987, 32'sh0, 0);
    push_load(8'd0, 8'd0, 1);
    push_load(8'd255, 8'd255, 0);
    push_eval(32'sh00FF8000, 32'sh00FF8000, 32'sh00FF8000, 0);
    push_eval(32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 0);
    for (int i = 0; i < 1660; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_load(8'($urandom), 8'($urandom), (i % 400) == 399);
      else
        push_eval(rand_coord(), rand_coord(),
                  ($urandom_range(0, 3) == 0) ? 32'sh0 : rand_coord(), (i % 400) == 399);
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_LOAD;
    in_if.entry_index = '0;
    in_if.entry_value = '0;
    in_if.x_coord = '0;
    in_if.y_coord = '0;
    in_if.z_coord = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        accepted_reqs++;
        if (in_if.action == ACT_LOAD)
          perm_shadow[in_if.entry_index] = in_if.entry_value;
        else
          noise_expected.push_back(noise_at(in_if.x_coord, in_if.y_coord, in_if.z_coord));
        if (!tail_phase && ((accepted_reqs / 150) % 3) != 0 &&
            $urandom_range(0, ((accepted_reqs / 150) % 3 == 1) ? 15 : 3) == 0)
          send_gap = $urandom_range(1, 15);
      end
      tail_phase = pending_reqs.size() < TAIL_ITEMS;
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].hold || noise_expected.size() == 0)) begin
          point_req_t r;
          r = pending_reqs.pop_front();
          in_if.valid <= 1'b1;
          in_if.action <= r.act;
          in_if.entry_index <= r.idx;
          in_if.entry_value <= r.val;
          in_if.x_coord <= r.x;
          in_if.y_coord <= r.y;
          in_if.z_coord <= r.z;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (noise_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result noise_value=%0d", out_if.noise_value);
        end else begin
          logic signed [15:0] want;
          want = noise_expected.pop_front();
          if (out_if.noise_value !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("noise_value mismatch: expected %0d actual %0d", want,
                       out_if.noise_value);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!tail_phase && $urandom_range(0, 11) == 0) recv_stall = $urandom_range(1, 15);
      end
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    while (pending_reqs.size() > 0 || in_if.valid) @(posedge clk_i);
    while (noise_expected.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && noise_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/gn3_pkg.sv
rtl/gn3_if.sv
rtl/gn3_core.sv
rtl/gradient_noise_3d.sv
tb/gradient_noise_3d_tb.sv
